// ----- sv/assert_macros.svh -----
// assertion helpers, clocked on clk and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every cycle out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold when the antecedent holds
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/gnmc_pkg.sv -----
package gnmc_pkg;

    typedef enum logic
    {
        OP_CELL  = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    // register index as seen on paddr[2]
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic [7:0] MINE_CHAR  = 8'd42;
    localparam logic [7:0] DIGIT_BASE = 8'd48;

    localparam logic [10:0] COLUMNS_RESET = 11'd1;
    localparam logic [11:0] ROWS_RESET    = 12'd1;

    // two line store bits of one column: bit 1 two rows up, bit 0 one row up
    typedef logic [1:0] line_word_t;

endpackage

// ----- sv/grid_neighbor_mine_count.sv -----
// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------
// input    | in_valid, in_ready  | opcode, is_mine
// output   | out_valid, out_ready| cell_char, neighbor_count, last_of_field
// config   | psel/penable/pwrite | paddr, pwdata, prdata (pready tied high)
//
// one item per cycle while the output is not stalled; an item passes through the window stage and its
// result is then held in the output register until taken.
// each result appears grid_columns + 1 items after its cell.
// the line store is a 2-bit wide memory read into a register at the input column when an item is
// accepted, with a bypass for a write to the same column in that cycle.
// rst_n clears control state only; stale line data is masked by row position.
// a stalled output holds the window stage, and the input backs up after it.
`include "assert_macros.svh"

module grid_neighbor_mine_count
    import gnmc_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic        is_mine,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  cell_char,
    output logic [3:0]  neighbor_count,
    output logic        last_of_field
);

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int EW    = (COL_W + 1 > 11) ? COL_W + 1 : 11;

    logic [10:0] grid_columns_reg;
    logic [11:0] grid_rows_reg;

    logic [COL_W-1:0] input_column_reg, input_column_next;
    logic [12:0]      input_row_reg, input_row_next;

    logic             s1_valid_reg;
    logic             s1_bit_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic             s1_first_reg;
    logic             s1_ge1_reg;
    logic             s1_ge2_reg;
    logic [COL_W-1:0] s1_col_reg;
    line_word_t       rd_word_reg;

    logic [8:0] window_reg, window_next;

    line_word_t line_mem [MAX_COLUMNS];

    logic [7:0] cell_char_reg;
    logic [3:0] count_reg;
    logic       last_reg;
    logic       out_valid_reg;

    logic        cfg_wr;
    logic        accept;
    logic        s1_fire;
    logic [EW-1:0] eff_cols;
    logic [12:0] eff_rows;
    logic [EW-1:0] col_inc;
    logic        col_first;
    logic        cell_bit;
    logic        emit;
    logic        last;
    line_word_t  wr_word;
    logic [2:0]  triple;
    logic [8:0]  win_emit;
    logic [3:0]  count;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_ROWS) ? 32'(grid_rows_reg) : 32'(grid_columns_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= COLUMNS_RESET;
            grid_rows_reg    <= ROWS_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_ROWS)
                grid_rows_reg <= pwdata[11:0];
            else
                grid_columns_reg <= pwdata[10:0];
        end
    end

    always_comb
    begin
        if (grid_columns_reg == 11'd0)
            eff_cols = EW'(1);
        else if (EW'(grid_columns_reg) > EW'(MAX_COLUMNS))
            eff_cols = EW'(MAX_COLUMNS);
        else
            eff_cols = EW'(grid_columns_reg);
        eff_rows = (grid_rows_reg == 12'd0) ? 13'd1 : 13'(grid_rows_reg);
    end

    // handshake
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept   = in_valid && in_ready;

    // input side: position, cell bit and emit decision
    always_comb
    begin
        col_first = (input_column_reg == '0);
        cell_bit  = (opcode == OP_CELL) && is_mine && (input_row_reg < eff_rows);
        emit      = col_first ? (input_row_reg >= 13'd2)
                              : ((input_row_reg >= 13'd1) && (input_row_reg <= eff_rows));
        // the last result comes from the first column of the second row below the grid
        last      = col_first && (input_row_reg == eff_rows + 13'd1);
        col_inc   = EW'(input_column_reg) + EW'(1);
        if (last)
        begin
            input_column_next = '0;
            input_row_next    = '0;
        end
        else if (col_inc >= eff_cols)
        begin
            input_column_next = '0;
            input_row_next    = input_row_reg + 13'd1;
        end
        else
        begin
            input_column_next = col_inc[COL_W-1:0];
            input_row_next    = input_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_column_reg <= '0;
            input_row_reg    <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else if (cfg_wr)
        begin
            input_column_reg <= '0;
            input_row_reg    <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                input_column_reg <= input_column_next;
                input_row_reg    <= input_row_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bit_reg   <= cell_bit;
            s1_emit_reg  <= emit;
            s1_last_reg  <= last;
            s1_first_reg <= col_first;
            s1_ge1_reg   <= (input_row_reg >= 13'd1);
            s1_ge2_reg   <= (input_row_reg >= 13'd2);
            s1_col_reg   <= input_column_reg;
        end
    end

    // line store: rows shift down by one at the item's column
    assign wr_word = {rd_word_reg[0], s1_bit_reg};

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            line_mem[s1_col_reg] <= wr_word;
        if (accept)
        begin
            if (s1_fire && (s1_col_reg == input_column_reg))
                rd_word_reg <= wr_word;
            else
                rd_word_reg <= line_mem[input_column_reg];
        end
    end

    // window stage
    always_comb
    begin
        triple = {s1_bit_reg, s1_ge1_reg && rd_word_reg[0], s1_ge2_reg && rd_word_reg[1]};
        // at a row start the centre is the previous row's last cell, with nothing right of it
        win_emit = s1_first_reg ? {3'b000, window_reg[8:3]} : {triple, window_reg[8:3]};
        count = 4'(win_emit[0]) + 4'(win_emit[1]) + 4'(win_emit[2]) + 4'(win_emit[3])
              + 4'(win_emit[5]) + 4'(win_emit[6]) + 4'(win_emit[7]) + 4'(win_emit[8]);
        if (s1_last_reg)
            window_next = '0;
        else if (s1_first_reg)
            window_next = {triple, 6'b000000};
        else
            window_next = {triple, window_reg[8:3]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else if (cfg_wr)
            window_reg <= '0;
        else if (s1_fire)
            window_reg <= window_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= s1_emit_reg;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emit_reg)
        begin
            cell_char_reg <= win_emit[4] ? MINE_CHAR : (DIGIT_BASE + 8'(count));
            count_reg     <= count;
            last_reg      <= s1_last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cell_char      = cell_char_reg;
    assign neighbor_count = count_reg;
    assign last_of_field  = last_reg;

    `ASSERT_ALWAYS(a_col_in_range, EW'(input_column_reg) < eff_cols, "input column past row end")
    `ASSERT_ALWAYS(a_row_in_range, input_row_reg <= eff_rows + 13'd1, "input row past drain row")
    `ASSERT_IMPLIES(a_digit_char, out_valid && (cell_char != MINE_CHAR), cell_char == DIGIT_BASE + 8'(neighbor_count), "digit does not match count")
    `ASSERT_IMPLIES(a_last_first_col, s1_valid_reg && s1_last_reg, s1_first_reg && s1_emit_reg, "last result not from a row start")

endmodule
